// ===== hdl/cdq_pkg.sv =====
// Shared types and constants for the circular double-ended queue.
// Holds the capacity, operation and status codes, and the word structs.
// No dependencies; every other file in hdl imports this package.
package cdq_pkg;

  // Storage geometry.
  localparam int unsigned CAPACITY = 128;
  localparam int unsigned PTR_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Field widths of the request and response words.
  localparam int unsigned OP_W     = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 8;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;

  // One request word.
  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
  } req_t;

  // One response word.
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] data;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
    logic                     is_full;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the incoming request word
    logic exec;  // perform the operation on pointers and store
  } cmd_t;

endpackage

// ===== hdl/cdq_ctrl.sv =====
// Controller state machine of the circular deque.
// Sequences capture, execution and response of one request word.
// Depends on cdq_pkg.
module cdq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  output cdq_pkg::cmd_t cmd_o
);
  import cdq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign accept = start && (state_q == S_IDLE);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: state_d = S_RESP;
      S_RESP: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Command and handshake outputs.
  assign busy       = (state_q != S_IDLE);
  assign done_o     = (state_q == S_RESP);
  assign cmd_o.load = accept;
  assign cmd_o.exec = (state_q == S_EXEC);

endmodule

// ===== hdl/cdq_dpath.sv =====
// Datapath of the circular deque: request register, head and tail pointers,
// occupancy counter and the word store with a registered read port.
// Depends on cdq_pkg.
module cdq_dpath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cdq_pkg::cmd_t cmd_i,
  input  cdq_pkg::req_t req_i,
  output cdq_pkg::rsp_t rsp_o
);
  import cdq_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];

  logic [OP_W-1:0]     op_q;
  logic [DATA_W-1:0]   value_q;
  logic [PTR_W-1:0]    head_q, head_d;
  logic [PTR_W-1:0]    tail_q, tail_d;
  logic [CNT_W-1:0]    occ_q, occ_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                dvld_q, dvld_d;
  logic [DATA_W-1:0]   rd_q;

  logic              empty, full;
  logic              wr_en, rd_en;
  logic [PTR_W-1:0]  wr_addr, rd_addr;
  logic [PTR_W-1:0]  head_prev, head_next, tail_prev, tail_next;

  // Capture the request word when the controller accepts it.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= req_i.op;
      value_q <= req_i.value;
    end
  end

  assign empty = (occ_q == '0);
  assign full  = (occ_q == CNT_W'(CAPACITY));

  // Circular neighbors of the pointers.
  assign head_prev = (head_q == '0) ? PTR_W'(CAPACITY - 1) : head_q - 1'b1;
  assign head_next = (head_q == PTR_W'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
  assign tail_prev = (tail_q == '0) ? PTR_W'(CAPACITY - 1) : tail_q - 1'b1;
  assign tail_next = (tail_q == PTR_W'(CAPACITY - 1)) ? '0 : tail_q + 1'b1;

  // Operation decode: pointer, count and store access for this request.
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    occ_d    = occ_q;
    status_d = ST_OK;
    dvld_d   = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    wr_addr  = '0;
    rd_addr  = head_q;
    unique case (op_q) inside
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          status_d = ST_OVER;
        end else begin
          wr_en = 1'b1;
          occ_d = occ_q + 1'b1;
          if (empty) begin
            head_d  = '0;
            tail_d  = '0;
            wr_addr = '0;
          end else if (op_q == OP_PUSH_FRONT) begin
            head_d  = head_prev;
            wr_addr = head_prev;
          end else begin
            tail_d  = tail_next;
            wr_addr = tail_next;
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
        if (empty) begin
          status_d = ST_UNDER;
        end else begin
          rd_en   = 1'b1;
          dvld_d  = 1'b1;
          rd_addr = (op_q == OP_POP_FRONT || op_q == OP_PEEK_FRONT) ? head_q : tail_q;
          if (op_q == OP_POP_FRONT || op_q == OP_POP_BACK) begin
            occ_d = occ_q - 1'b1;
            if (occ_q > CNT_W'(1)) begin
              if (op_q == OP_POP_FRONT) head_d = head_next;
              else                      tail_d = tail_prev;
            end
          end
        end
      end
      default: begin
        // Unused operation codes leave everything unchanged.
      end
    endcase
  end

  // Pointer and occupancy registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      occ_q  <= '0;
    end else if (cmd_i.exec) begin
      head_q <= head_d;
      tail_q <= tail_d;
      occ_q  <= occ_d;
    end
  end

  // Word store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem[wr_addr] <= value_q;
    end
    if (cmd_i.exec && rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Response attributes captured with the operation.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      dvld_q   <= dvld_d;
    end
  end

  // Response word; count and flags reflect the updated occupancy.
  assign rsp_o.status   = status_q;
  assign rsp_o.data     = dvld_q ? rd_q : '0;
  assign rsp_o.count    = COUNT_W'(occ_q);
  assign rsp_o.is_empty = (occ_q == '0);
  assign rsp_o.is_full  = (occ_q == CNT_W'(CAPACITY));

endmodule

// ===== hdl/circular_deque.sv =====
// Circular double-ended queue of signed 32-bit words, top level.
// done_o rises when the controller reaches its respond state, after the execute state
// that follows the edge at which start is taken. A new request word is taken only while
// idle: each passes through the capture, execute and respond steps of the controller.
// Reset clears pointers and count (deque empty); the receiver cannot stall.
module circular_deque (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  cdq_pkg::req_t req_i,
  output logic          done_o,
  output cdq_pkg::rsp_t rsp_o
);
  import cdq_pkg::*;

  cmd_t cmd;

  // Controller.
  cdq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // Datapath.
  cdq_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

  // A taken request makes the block busy on the next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request taken without going busy");

  // The empty flag and the count agree.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.is_empty == (rsp_o.count == '0)))
    else $error("empty flag disagrees with count");

  // A refused request returns no word.
  a_err_nodata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != ST_OK |-> rsp_o.data == '0)
    else $error("data returned on refused request");

  // Full and empty never hold together.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(rsp_o.is_empty && rsp_o.is_full))
    else $error("full and empty both set");

endmodule
